@@ rtl/core/tfa_pkg.sv @@
// Shared types and constants of the ticket FIFO resource arbiter.
`default_nettype none

package tfa_pkg;

    // Fixed field widths of the channels
    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 4;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_MISS       = 2'd1,
        ST_FULL       = 2'd2,
        ST_NOT_HOLDER = 2'd3
    } t_status;

    // Largest rank that the result field can show
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

endpackage

`default_nettype wire

@@ rtl/core/tfa_req_if.sv @@
// Operation channel: one operation with its requester id per transfer.
`default_nettype none

interface tfa_req_if
    import tfa_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] requester_id;

    modport source (output valid, output operation, output requester_id, input ready);
    modport sink   (input valid, input operation, input requester_id, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tfa_rsp_if.sv @@
// Result channel: status, rank, grant and handoff per transfer.
`default_nettype none

interface tfa_rsp_if
    import tfa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   rank;
    logic                granted;
    logic                next_valid;
    logic [ID_W-1:0]     next_holder;

    modport source (output valid, output status, output rank, output granted,
                    output next_valid, output next_holder, input ready);
    modport sink   (input valid, input status, input rank, input granted,
                    input next_valid, input next_holder, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tfa_owner_ram.sv @@
// Ticket owner memory: one write port, one read port with registered data.
`default_nettype none

module tfa_owner_ram
    import tfa_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]  o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write the owner of a new ticket
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, updated only when the read is enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/core/tfa_ctrl.sv @@
// Arbiter sequencer: slot scan, ticket pointers, valid bits and result register.
`default_nettype none

module tfa_ctrl
    import tfa_pkg::*;
#(
    parameter int QUEUE_SLOTS = 16,
    parameter int ID_BITS     = 16,
    parameter int TW          = 4,
    parameter int OW          = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    tfa_req_if.sink            i_req,
    tfa_rsp_if.source          o_rsp,
    output      logic          o_rd_en,
    output      logic [TW-1:0] o_rd_addr,
    input  wire logic [ID_BITS-1:0] i_rd_data,
    output      logic          o_wr_en,
    output      logic [TW-1:0] o_wr_addr,
    output      logic [ID_BITS-1:0] o_wr_data
);

    localparam int KW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int DW = (TW > RANK_W) ? TW : RANK_W;
    localparam logic [TW-1:0] LAST_TICKET = TW'(QUEUE_SLOTS - 1);
    localparam logic [OW-1:0] OCC_FULL    = OW'(QUEUE_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_RD_NEXT,
        S_NEXT
    } t_state;

    t_state               r_state;
    logic [OP_W-1:0]      r_op;
    logic [ID_BITS-1:0]   r_key;
    logic [OW-1:0]        r_iss_cnt;
    logic                 r_cmp_vld;
    logic [TW-1:0]        r_cmp_idx;
    logic                 r_found;
    logic [TW-1:0]        r_hit_idx;
    logic [QUEUE_SLOTS-1:0] r_slot_vld;
    logic [TW-1:0]        r_next_ticket;
    logic [TW-1:0]        r_serving;
    logic [OW-1:0]        r_occ;

    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [RANK_W-1:0]    r_out_rank;
    logic                 r_out_granted;
    logic                 r_out_nvalid;
    logic [ID_W-1:0]      r_out_nholder;

    logic                 w_out_free;
    logic                 w_issue;
    logic                 w_hit;
    logic                 w_exec;
    logic                 w_do_req;
    logic [TW-1:0]        w_req_dist;
    logic [TW-1:0]        w_hit_dist;
    logic [TW-1:0]        w_after_hit;

    // Distance of a ticket from the serving ticket around the ring
    function automatic logic [TW-1:0] f_dist(input logic [TW-1:0] t, input logic [TW-1:0] s);
        logic [TW:0] sum;
        sum = {1'b0, t} + (TW+1)'(QUEUE_SLOTS) - {1'b0, s};
        if (t >= s) begin
            return t - s;
        end
        return sum[TW-1:0];
    endfunction

    // Clamp a distance to the rank field
    function automatic logic [RANK_W-1:0] f_sat(input logic [TW-1:0] d);
        logic [DW-1:0] x;
        x = DW'(d);
        if (x > DW'(RANK_MAX)) begin
            return RANK_MAX;
        end
        return x[RANK_W-1:0];
    endfunction

    function automatic logic [TW-1:0] f_wrap_inc(input logic [TW-1:0] t);
        if (t == LAST_TICKET) begin
            return '0;
        end
        return t + TW'(1);
    endfunction

    // Decode scan and execute conditions
    always_comb begin
        w_out_free  = !r_out_valid || o_rsp.ready;
        w_issue     = (r_state == S_SCAN) && (r_iss_cnt < OCC_FULL);
        w_hit       = r_cmp_vld && r_slot_vld[r_cmp_idx] && (i_rd_data == r_key);
        w_exec      = (r_state == S_EXEC) && w_out_free;
        w_do_req    = w_exec && (r_op == OP_REQUEST) && !r_found && (r_occ != OCC_FULL);
        w_req_dist  = f_dist(r_next_ticket, r_serving);
        w_hit_dist  = f_dist(r_hit_idx, r_serving);
        w_after_hit = f_wrap_inc(r_hit_idx);
    end

    // Drive the owner memory ports
    always_comb begin
        o_rd_en   = w_issue || (r_state == S_RD_NEXT);
        o_rd_addr = (r_state == S_RD_NEXT) ? r_serving : r_iss_cnt[TW-1:0];
        o_wr_en   = w_do_req;
        o_wr_addr = r_next_ticket;
        o_wr_data = r_key;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.rank        = r_out_rank;
    assign o_rsp.granted     = r_out_granted;
    assign o_rsp.next_valid  = r_out_nvalid;
    assign o_rsp.next_holder = r_out_nholder;

    // Sequence one operation: scan, update, fetch the next owner on a handoff, then load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cmp_vld     <= 1'b0;
            r_found       <= 1'b0;
            r_iss_cnt     <= '0;
            r_slot_vld    <= '0;
            r_next_ticket <= '0;
            r_serving     <= '0;
            r_occ         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // Drop the result once the sink takes it
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op      <= i_req.operation;
                        r_key     <= ID_BITS'(i_req.requester_id[KW-1:0]);
                        r_iss_cnt <= '0;
                        r_cmp_vld <= 1'b0;
                        r_found   <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    // Issue one slot read per cycle, compare the previous one
                    r_cmp_vld <= w_issue;
                    r_cmp_idx <= r_iss_cnt[TW-1:0];
                    if (w_issue) begin
                        r_iss_cnt <= r_iss_cnt + OW'(1);
                    end
                    if (w_hit) begin
                        r_found   <= 1'b1;
                        r_hit_idx <= r_cmp_idx;
                        r_state   <= S_EXEC;
                    end else if (r_cmp_vld && (r_cmp_idx == LAST_TICKET)) begin
                        r_state   <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= ST_MISS;
                        r_out_rank    <= '0;
                        r_out_granted <= 1'b0;
                        r_out_nvalid  <= 1'b0;
                        r_out_nholder <= '0;
                        r_state       <= S_IDLE;
                        case (r_op)
                            OP_REQUEST: begin
                                if (r_found) begin
                                    r_out_status <= ST_MISS;
                                end else if (r_occ == OCC_FULL) begin
                                    r_out_status <= ST_FULL;
                                end else begin
                                    r_slot_vld[r_next_ticket] <= 1'b1;
                                    r_next_ticket <= f_wrap_inc(r_next_ticket);
                                    r_occ         <= r_occ + OW'(1);
                                    r_out_status  <= ST_OK;
                                    r_out_rank    <= f_sat(w_req_dist);
                                    r_out_granted <= (w_req_dist == '0);
                                end
                            end
                            OP_RELEASE: begin
                                if (!r_found) begin
                                    r_out_status <= ST_MISS;
                                end else if (r_hit_idx != r_serving) begin
                                    r_out_status <= ST_NOT_HOLDER;
                                end else begin
                                    r_slot_vld[r_hit_idx] <= 1'b0;
                                    r_occ        <= r_occ - OW'(1);
                                    r_serving    <= w_after_hit;
                                    r_out_status <= ST_OK;
                                    // Hand off: fetch the next owner first
                                    if ((r_occ > OW'(1)) && r_slot_vld[w_after_hit]) begin
                                        r_out_valid <= 1'b0;
                                        r_state     <= S_RD_NEXT;
                                    end
                                end
                            end
                            OP_QUERY: begin
                                if (r_found) begin
                                    r_out_status  <= ST_OK;
                                    r_out_rank    <= f_sat(w_hit_dist);
                                    r_out_granted <= (w_hit_dist == '0);
                                end
                            end
                            default: begin
                                r_out_status <= ST_MISS;
                            end
                        endcase
                    end
                end

                S_RD_NEXT: begin
                    r_state <= S_NEXT;
                end

                S_NEXT: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_nvalid  <= 1'b1;
                        r_out_nholder <= ID_W'(i_rd_data[KW-1:0]);
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ticket_fifo_resource_arbiter.sv @@
// Top level of the ticket FIFO resource arbiter.
//
//  channel   dir   transfer when          payload
//  i_req     in    valid && ready         operation, requester_id
//  o_rsp     out   valid && ready         status, rank, granted, next_valid, next_holder
//
// An operation scans the ticket slots through the owner memory, one read per
// cycle, stopping at the first match; a release that hands the resource on
// then reads the next owner. The single memory read port sets the scan rate.
// Reset clears the slot valid bits, pointers and occupancy. A new operation
// is taken while a result still waits; the block stalls only when a finished
// result finds the output register still full.
`default_nettype none

module ticket_fifo_resource_arbiter
    import tfa_pkg::*;
#(
    parameter int QUEUE_SLOTS = 16,
    parameter int ID_BITS     = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tfa_req_if.sink   i_req,
    tfa_rsp_if.source o_rsp
);

    localparam int TW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int OW = $clog2(QUEUE_SLOTS + 1);

    logic               w_rd_en;
    logic [TW-1:0]      w_rd_addr;
    logic [ID_BITS-1:0] w_rd_data;
    logic               w_wr_en;
    logic [TW-1:0]      w_wr_addr;
    logic [ID_BITS-1:0] w_wr_data;

    // Sequencer with the ticket state and result register
    tfa_ctrl #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .ID_BITS     (ID_BITS),
        .TW          (TW),
        .OW          (OW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data)
    );

    // Owner id of each ticket
    tfa_owner_ram #(
        .DEPTH  (QUEUE_SLOTS),
        .WIDTH  (ID_BITS),
        .ADDR_W (TW)
    ) u_owner_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

endmodule

`default_nettype wire
